FILE: hw/rtl/adq_pkg.sv
package adq_pkg;

  // command codes as carried in the input word
  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_MODIFY     = 3'd4,
    CMD_LIST       = 3'd5
  } cmd_e;

  // result status codes
  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_OVERFLOW  = 3'd1,
    STAT_UNDERFLOW = 3'd2,
    STAT_BADPOS    = 3'd3,
    STAT_EMPTY     = 3'd4
  } status_e;

  // classified operation kinds
  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_MODIFY = 2'd2,
    OP_LIST   = 2'd3
  } op_kind_e;

  // back engine states
  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_POP  = 2'd1,
    BK_LIST = 2'd2
  } bk_state_e;

  localparam int unsigned WordW = 32;
  localparam int unsigned PosW  = 6;
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [2:0]              cmd;
    logic signed [WordW-1:0] value;
    logic [PosW-1:0]         position;
  } adq_in_t;

  typedef struct packed {
    logic [2:0]              status;
    logic signed [WordW-1:0] data;
    logic                    last;
  } adq_out_t;

  // decoded operation handed from front to back
  typedef struct packed {
    op_kind_e                kind;
    logic                    at_rear;
    logic signed [WordW-1:0] value;
    logic [PosW-1:0]         position;
  } adq_op_t;

endpackage

FILE: hw/rtl/adq_ram.sv
module adq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/adq_front.sv
module adq_front (
  input  logic             start_i,
  input  adq_pkg::adq_in_t req_i,
  input  logic             q_full_i,
  output logic             busy_o,
  output logic             q_push_o,
  output adq_pkg::adq_op_t q_op_o
);
  import adq_pkg::*;

  logic accept;
  logic known;

  assign busy_o = q_full_i;
  assign accept = start_i && !q_full_i;

  // undefined command codes are dropped here and never reach the back
  always_comb begin
    known          = 1'b1;
    q_op_o.kind    = OP_PUSH;
    q_op_o.at_rear = 1'b0;
    q_op_o.value   = req_i.value;
    q_op_o.position = req_i.position;
    case (req_i.cmd)
      CMD_PUSH_FRONT: q_op_o.kind = OP_PUSH;
      CMD_PUSH_REAR: begin
        q_op_o.kind    = OP_PUSH;
        q_op_o.at_rear = 1'b1;
      end
      CMD_POP_FRONT: q_op_o.kind = OP_POP;
      CMD_POP_REAR: begin
        q_op_o.kind    = OP_POP;
        q_op_o.at_rear = 1'b1;
      end
      CMD_MODIFY: q_op_o.kind = OP_MODIFY;
      CMD_LIST:   q_op_o.kind = OP_LIST;
      default:    known = 1'b0;
    endcase
  end

  assign q_push_o = accept && known;

endmodule

FILE: hw/rtl/adq_cmd_queue.sv
module adq_cmd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  adq_pkg::adq_op_t op_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             valid_o,
  output adq_pkg::adq_op_t op_o
);
  import adq_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  adq_op_t         ent_q [QueueDepth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign op_o    = ent_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wptr_q] <= op_i;
    end
  end

endmodule

FILE: hw/rtl/adq_back.sv
module adq_back #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  input  adq_pkg::adq_op_t          q_op_i,
  output logic                      q_pop_o,
  output logic                      ram_we_o,
  output logic [IW-1:0]             ram_waddr_o,
  output logic [adq_pkg::WordW-1:0] ram_wdata_o,
  output logic                      ram_re_o,
  output logic [IW-1:0]             ram_raddr_o,
  input  logic [adq_pkg::WordW-1:0] ram_rdata_i,
  output logic                      res_valid_o,
  output adq_pkg::adq_out_t         res_o
);
  import adq_pkg::*;

  bk_state_e state_q, state_d;
  logic [IW-1:0] head_q, head_d;
  logic [IW-1:0] tail_q, tail_d;
  logic          empty_q, empty_d;
  logic [IW-1:0] cur_q, cur_d;
  logic          res_valid_q, res_valid_d;
  adq_out_t      res_q, res_d;
  logic          pos_ok;

  // modify target must lie in head..tail of a non-empty deque
  assign pos_ok = !empty_q && (q_op_i.position >= PosW'(head_q)) &&
                  (q_op_i.position <= PosW'(tail_q));

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    empty_d     = empty_q;
    cur_d       = cur_q;
    res_valid_d = 1'b0;
    res_d       = '{status: STAT_OK, data: '0, last: 1'b1};
    q_pop_o     = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = head_q;
    ram_wdata_o = q_op_i.value;
    ram_re_o    = 1'b0;
    ram_raddr_o = q_op_i.at_rear ? tail_q : head_q;

    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          case (q_op_i.kind)
            OP_PUSH: begin
              res_valid_d = 1'b1;
              if (empty_q) begin
                head_d      = '0;
                tail_d      = '0;
                empty_d     = 1'b0;
                ram_we_o    = 1'b1;
                ram_waddr_o = '0;
              end else if (!q_op_i.at_rear) begin
                if (head_q == '0) begin
                  res_d.status = STAT_OVERFLOW;
                end else begin
                  head_d      = head_q - 1'b1;
                  ram_we_o    = 1'b1;
                  ram_waddr_o = head_q - 1'b1;
                end
              end else begin
                if (tail_q == IW'(DEPTH - 1)) begin
                  res_d.status = STAT_OVERFLOW;
                end else begin
                  tail_d      = tail_q + 1'b1;
                  ram_we_o    = 1'b1;
                  ram_waddr_o = tail_q + 1'b1;
                end
              end
            end
            OP_POP: begin
              if (empty_q) begin
                res_valid_d  = 1'b1;
                res_d.status = STAT_UNDERFLOW;
              end else begin
                ram_re_o = 1'b1;
                state_d  = BK_POP;
                if (head_q == tail_q) begin
                  empty_d = 1'b1;
                  head_d  = '0;
                  tail_d  = '0;
                end else if (q_op_i.at_rear) begin
                  tail_d = tail_q - 1'b1;
                end else begin
                  head_d = head_q + 1'b1;
                end
              end
            end
            OP_MODIFY: begin
              res_valid_d = 1'b1;
              if (pos_ok) begin
                ram_we_o    = 1'b1;
                ram_waddr_o = q_op_i.position[IW-1:0];
              end else begin
                res_d.status = STAT_BADPOS;
              end
            end
            OP_LIST: begin
              if (empty_q) begin
                res_valid_d  = 1'b1;
                res_d.status = STAT_EMPTY;
              end else begin
                ram_re_o    = 1'b1;
                ram_raddr_o = head_q;
                cur_d       = head_q;
                state_d     = BK_LIST;
              end
            end
            default: ;
          endcase
        end
      end
      BK_POP: begin
        res_valid_d = 1'b1;
        res_d.data  = ram_rdata_i;
        state_d     = BK_IDLE;
      end
      BK_LIST: begin
        res_valid_d = 1'b1;
        res_d.data  = ram_rdata_i;
        res_d.last  = (cur_q == tail_q);
        if (cur_q == tail_q) begin
          state_d = BK_IDLE;
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = cur_q + 1'b1;
          cur_d       = cur_q + 1'b1;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      empty_q     <= 1'b1;
      cur_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      empty_q     <= empty_d;
      cur_q       <= cur_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

FILE: hw/rtl/array_deque_engine_core.sv
// Double-ended queue of signed 32-bit words in a linear array of DEPTH slots
// (front grows toward slot 0, rear toward slot DEPTH-1, first push into an
// empty deque lands in slot 0). A command word is taken on a clock edge with
// start high and busy low; busy rises only while the two-entry command queue
// is full. Results come out one per cycle on res_o, marked by res_valid_o,
// and must be taken in that cycle: the receiver cannot hold them off.
// Push, modify and any error or empty result are answered from the idle
// state; a successful pop first issues the registered read of the slot RAM
// and answers from the pop state; a list issues the head read from idle,
// then answers one entry per list-state step, one RAM read per entry. Each
// command passes through the command queue and the result register, a pop
// or a list also through the slot RAM read register. Codes 6 and 7 are
// dropped with no result.
module array_deque_engine_core #(
  parameter int unsigned DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  adq_pkg::adq_in_t  req_i,
  output logic              res_valid_o,
  output adq_pkg::adq_out_t res_o
);
  import adq_pkg::*;

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // front to queue
  logic    q_push;
  adq_op_t q_in_op;
  logic    q_full;

  // queue to back
  logic    q_valid;
  adq_op_t q_out_op;
  logic    q_pop;

  // slot storage
  logic             ram_we;
  logic [IW-1:0]    ram_waddr;
  logic [WordW-1:0] ram_wdata;
  logic             ram_re;
  logic [IW-1:0]    ram_raddr;
  logic [WordW-1:0] ram_rdata;

  // decode and admission
  adq_front u_front (
    .start_i  (start),
    .req_i    (req_i),
    .q_full_i (q_full),
    .busy_o   (busy),
    .q_push_o (q_push),
    .q_op_o   (q_in_op)
  );

  // short decoupling queue between front and back
  adq_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .op_i    (q_in_op),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .op_o    (q_out_op)
  );

  // deque state, command execution and result word register
  adq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_op_i      (q_out_op),
    .q_pop_o     (q_pop),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // slot array, only live slots are ever read
  adq_ram #(
    .WIDTH (WordW),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

FILE: sim/array_deque_engine_core_tb.sv
module array_deque_engine_core_tb;
  import adq_pkg::*;

  localparam int unsigned SLOTS         = 64;
  localparam int unsigned CYCLE_LIMIT   = 300000;
  // the longest list gives SLOTS result words; this wait covers any word still in flight
  localparam int unsigned SETTLE_CYCLES = 80;

  // codes 6 and 7 are not commands, the block drops them
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  adq_in_t  req_i;
  logic     res_valid_o;
  adq_out_t res_o;

  array_deque_engine_core #(
    .DEPTH(SLOTS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // shadow copy of the deque, updated when a command word is taken
  logic signed [31:0] shadow_slots [SLOTS];
  int                 shadow_head  = 0;
  int                 shadow_tail  = 0;
  bit                 shadow_empty = 1'b1;

  // result words still owed by the block, oldest first
  adq_out_t pending_words [$];

  int  fail_count     = 0;
  int  cycle_count    = 0;
  int  items_sent     = 0;
  int  words_checked  = 0;
  int  list_words     = 0;
  int  overflow_seen  = 0;
  int  underflow_seen = 0;
  int  badpos_seen    = 0;
  int  empty_seen     = 0;
  bit  no_idle        = 1'b0;

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic void owe_word(status_e status, logic signed [31:0] data, logic last);
    adq_out_t w;
    w.status = status;
    w.data   = data;
    w.last   = last;
    pending_words.push_back(w);
    case (status)
      STAT_OVERFLOW:  overflow_seen++;
      STAT_UNDERFLOW: underflow_seen++;
      STAT_BADPOS:    badpos_seen++;
      STAT_EMPTY:     empty_seen++;
      default: ;
    endcase
  endfunction

  // deque behavior: what one accepted command does to the shadow and what it answers
  function automatic void predict_deque(adq_in_t w);
    int i;
    case (w.cmd)
      CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
        if (shadow_empty) begin
          // first word always lands in slot 0, whichever end
          shadow_head     = 0;
          shadow_tail     = 0;
          shadow_empty    = 1'b0;
          shadow_slots[0] = w.value;
          owe_word(STAT_OK, '0, 1'b1);
        end else if (w.cmd == CMD_PUSH_FRONT) begin
          if (shadow_head == 0) begin
            owe_word(STAT_OVERFLOW, '0, 1'b1);
          end else begin
            shadow_head--;
            shadow_slots[shadow_head] = w.value;
            owe_word(STAT_OK, '0, 1'b1);
          end
        end else begin
          if (shadow_tail >= SLOTS - 1) begin
            owe_word(STAT_OVERFLOW, '0, 1'b1);
          end else begin
            shadow_tail++;
            shadow_slots[shadow_tail] = w.value;
            owe_word(STAT_OK, '0, 1'b1);
          end
        end
      end
      CMD_POP_FRONT, CMD_POP_REAR: begin
        if (shadow_empty) begin
          owe_word(STAT_UNDERFLOW, '0, 1'b1);
        end else begin
          if (w.cmd == CMD_POP_FRONT) owe_word(STAT_OK, shadow_slots[shadow_head], 1'b1);
          else owe_word(STAT_OK, shadow_slots[shadow_tail], 1'b1);
          if (shadow_head >= shadow_tail) begin
            // last entry gone, indexes fall back to slot 0
            shadow_empty = 1'b1;
            shadow_head  = 0;
            shadow_tail  = 0;
          end else if (w.cmd == CMD_POP_FRONT) begin
            shadow_head++;
          end else begin
            shadow_tail--;
          end
        end
      end
      CMD_MODIFY: begin
        if (shadow_empty || int'(w.position) < shadow_head || int'(w.position) > shadow_tail) begin
          owe_word(STAT_BADPOS, '0, 1'b1);
        end else begin
          shadow_slots[w.position] = w.value;
          owe_word(STAT_OK, '0, 1'b1);
        end
      end
      CMD_LIST: begin
        if (shadow_empty) begin
          owe_word(STAT_EMPTY, '0, 1'b1);
        end else begin
          for (i = shadow_head; i <= shadow_tail; i++) begin
            owe_word(STAT_OK, shadow_slots[i], i == shadow_tail);
            list_words++;
          end
        end
      end
      default: ;
    endcase
  endfunction

  // mostly random words, with the corners of the signed range mixed in
  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // send one command word: optional idle gap, then hold start until taken
  task automatic send_word(input logic [2:0] cmd, input logic signed [31:0] value,
                           input logic [5:0] position);
    int      gap;
    adq_in_t w;
    gap        = no_idle ? 0 : $urandom_range(0, 6);
    w.cmd      = cmd;
    w.value    = value;
    w.position = position;
    @(negedge clk_i);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_i = w;
    start = 1'b1;
    // taken on the first rising edge that sees busy low
    do @(posedge clk_i); while (busy);
    predict_deque(w);
    items_sent++;
  endtask

  // stop sending and let every owed word come out
  task automatic wait_drained();
    @(negedge clk_i);
    start = 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // every command but push rear against the reset state, plus the dropped codes
  task automatic test_empty_deque();
    send_word(CMD_POP_FRONT, rand_word(), 6'd0);
    send_word(CMD_POP_REAR, rand_word(), 6'd0);
    send_word(CMD_MODIFY, 32'h1234_5678, 6'd0);
    send_word(CMD_MODIFY, 32'h1234_5678, 6'h3f);
    send_word(CMD_LIST, rand_word(), 6'd0);
    send_word(CMD_SPARE_6, 32'hffff_ffff, 6'h3f);
    send_word(CMD_SPARE_7, 32'h0000_0000, 6'd0);
    // push front into empty deque lands in slot 0, a second one overflows
    send_word(CMD_PUSH_FRONT, 32'h8000_0000, 6'd0);
    send_word(CMD_PUSH_FRONT, 32'h7fff_ffff, 6'd0);
    send_word(CMD_POP_REAR, rand_word(), 6'd0);
    send_word(CMD_LIST, rand_word(), 6'd0);
  endtask

  // word extremes, in-range and out-of-range modify, popping down to empty
  task automatic test_edge_values();
    send_word(CMD_PUSH_REAR, 32'h7fff_ffff, 6'd0);
    send_word(CMD_PUSH_REAR, 32'hffff_ffff, 6'd0);
    send_word(CMD_PUSH_REAR, 32'h0000_0000, 6'd0);
    send_word(CMD_PUSH_FRONT, 32'h8000_0000, 6'd0);
    send_word(CMD_MODIFY, 32'h5555_5555, 6'd2);
    send_word(CMD_MODIFY, 32'haaaa_aaaa, 6'd3);
    send_word(CMD_MODIFY, 32'haaaa_aaaa, 6'h3f);
    send_word(CMD_LIST, rand_word(), 6'd0);
    send_word(CMD_POP_FRONT, rand_word(), 6'd0);
    send_word(CMD_PUSH_FRONT, 32'haaaa_aaaa, 6'd0);
    send_word(CMD_MODIFY, 32'h8000_0000, 6'd0);
    send_word(CMD_POP_FRONT, rand_word(), 6'd0);
    send_word(CMD_POP_REAR, rand_word(), 6'd0);
    send_word(CMD_POP_REAR, rand_word(), 6'd0);
    send_word(CMD_POP_FRONT, rand_word(), 6'd0);
    send_word(CMD_LIST, rand_word(), 6'd0);
  endtask

  // full deque at both ends: rear overflow, full list, then a deque pinned at the top slot
  task automatic test_fill_and_drain();
    int k;
    for (k = 0; k < SLOTS; k++) send_word(CMD_PUSH_REAR, $urandom(), 6'($urandom_range(0, 63)));
    send_word(CMD_PUSH_REAR, rand_word(), 6'd0);
    send_word(CMD_PUSH_FRONT, rand_word(), 6'd0);
    send_word(CMD_LIST, rand_word(), 6'd0);
    send_word(CMD_MODIFY, 32'h5a5a_5a5a, 6'h3f);
    send_word(CMD_MODIFY, 32'ha5a5_a5a5, 6'd0);
    // hold off until the long list has fully drained
    wait_drained();
    for (k = 0; k < SLOTS - 1; k++) send_word(CMD_POP_FRONT, rand_word(), 6'd0);
    send_word(CMD_MODIFY, rand_word(), 6'd62);
    send_word(CMD_PUSH_REAR, rand_word(), 6'd0);
    send_word(CMD_LIST, rand_word(), 6'd0);
    for (k = 0; k < 3; k++) send_word(CMD_PUSH_FRONT, rand_word(), 6'd0);
    for (k = 0; k < 5; k++) send_word(CMD_POP_REAR, rand_word(), 6'd0);
  endtask

  // weighted random traffic, biased so the deque drifts across the whole array
  task automatic test_random_traffic(input int count);
    int         real_items;
    int         pick;
    logic [2:0] cmd;
    logic [5:0] pos;
    real_items = 0;
    while (real_items < count) begin
      // alternate stretches of back-to-back commands with idling ones
      if (items_sent % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 33) cmd = CMD_PUSH_REAR;
      else if (pick < 48) cmd = CMD_PUSH_FRONT;
      else if (pick < 68) cmd = CMD_POP_FRONT;
      else if (pick < 78) cmd = CMD_POP_REAR;
      else if (pick < 90) cmd = CMD_MODIFY;
      else if (pick < 96) cmd = CMD_LIST;
      else cmd = pick[0] ? CMD_SPARE_7 : CMD_SPARE_6;
      // modify mostly hits live slots, sometimes anywhere
      if (!shadow_empty && $urandom_range(0, 3) != 0) begin
        pos = 6'($urandom_range(shadow_head, shadow_tail));
      end else begin
        pos = 6'($urandom_range(0, 63));
      end
      send_word(cmd, rand_word(), pos);
      if (cmd != CMD_SPARE_6 && cmd != CMD_SPARE_7) real_items++;
    end
    no_idle = 1'b0;
  endtask

  // result checker: every strobed word against the oldest owed one
  always @(posedge clk_i) begin : check_words
    adq_out_t want;
    if (rst_ni && res_valid_o) begin
      if (pending_words.size() == 0) begin
        note_failure($sformatf("unexpected word status=%0d data=%0d last=%0b",
                               res_o.status, res_o.data, res_o.last));
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (res_o.status !== want.status || res_o.data !== want.data ||
            res_o.last !== want.last) begin
          note_failure($sformatf(
            "word %0d: expected status=%0d data=%0d last=%0b, got status=%0d data=%0d last=%0b",
            words_checked, want.status, want.data, want.last,
            res_o.status, res_o.data, res_o.last));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_deque();
    test_edge_values();
    test_fill_and_drain();
    test_random_traffic(310);
    wait_drained();

    $display("tb: %0d commands sent, %0d result words checked (%0d from lists)",
             items_sent, words_checked, list_words);
    $display("tb: overflow %0d, underflow %0d, bad position %0d, empty list %0d",
             overflow_seen, underflow_seen, badpos_seen, empty_seen);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/adq_pkg.sv
hw/rtl/adq_ram.sv
hw/rtl/adq_front.sv
hw/rtl/adq_cmd_queue.sv
hw/rtl/adq_back.sv
hw/rtl/array_deque_engine_core.sv
sim/array_deque_engine_core_tb.sv
